FILE: design/assert_macros.svh
// Assertion macros for the design files; tfn_back uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TFN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TFN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TFN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TFN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/tfn_pkg.sv
package tfn_pkg;
  localparam int POS_W = 32;
  localparam int NRM_W = 16;
  localparam int SUM_W = 18;
  localparam int VEC_W = 21;
  localparam int SQ_W = 44;
  localparam int REM_W = 38;
  localparam int QUO_W = 17;
  localparam int FALLBACK_LIMIT = 268;
  localparam int UNIT_Q14 = 16384;

  typedef logic [2:0][2:0][NRM_W-1:0] coef_t;

  typedef struct packed {
    logic [8:0][POS_W-1:0] pos;
    logic [2:0][SUM_W-1:0] nsum;
  } job_t;
endpackage

FILE: design/tfn_front.sv
module tfn_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [15:0] in_nrm_x,
  input  logic [15:0] in_nrm_y,
  input  logic [15:0] in_nrm_z,
  input  logic in_end_of_batch,
  input  logic q_full,
  output logic q_push,
  output tfn_pkg::job_t q_job
);
  import tfn_pkg::*;

  logic [1:0] slot_r, slot_nxt;
  logic [5:0][POS_W-1:0] held_r;
  logic [2:0][SUM_W-1:0] sum_r, sum_nxt, new_sum;
  logic [2:0][NRM_W-1:0] nrm;
  logic accept;

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;
  assign nrm = {in_nrm_z, in_nrm_y, in_nrm_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (slot_r == 2'd0) begin
        new_sum[k] = SUM_W'($signed(nrm[k]));
      end else begin
        new_sum[k] = sum_r[k] + SUM_W'($signed(nrm[k]));
      end
    end
    slot_nxt = slot_r;
    sum_nxt = sum_r;
    q_push = 1'b0;
    if (accept) begin
      if (slot_r < 2'd2) begin
        slot_nxt = slot_r + 2'd1;
        sum_nxt = new_sum;
        if (in_end_of_batch) begin
          slot_nxt = 2'd0;
          sum_nxt = '0;
        end
      end else begin
        q_push = 1'b1;
        slot_nxt = 2'd0;
        sum_nxt = '0;
      end
    end
    q_job.pos = {in_pos_z, in_pos_y, in_pos_x, held_r};
    q_job.nsum = new_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 2'd0;
      sum_r <= '0;
    end else begin
      slot_r <= slot_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && slot_r == 2'd0) begin
      held_r[2:0] <= {in_pos_z, in_pos_y, in_pos_x};
    end
    if (accept && slot_r == 2'd1) begin
      held_r[5:3] <= {in_pos_z, in_pos_y, in_pos_x};
    end
  end
endmodule

FILE: design/tfn_queue.sv
module tfn_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tfn_pkg::job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output tfn_pkg::job_t pop_job
);
  import tfn_pkg::*;

  job_t mem [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full = count_r == 2'd2;
  assign empty = count_r == 2'd0;
  assign pop_job = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: design/tfn_back.sv
`include "assert_macros.svh"

module tfn_back (
  input  logic clk,
  input  logic rst_n,
  input  tfn_pkg::coef_t coef,
  input  logic q_empty,
  input  tfn_pkg::job_t q_job,
  output logic q_pop,
  output logic out_valid,
  input  logic out_stall,
  output logic [8:0][31:0] out_pos,
  output logic [2:0][15:0] out_face
);
  import tfn_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_ROT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r;
  logic [8:0][POS_W-1:0] pos_r;
  logic signed [VEC_W-1:0] v_r [3];
  logic signed [NRM_W-1:0] n_r [3];
  logic signed [SQ_W-1:0] acc_r, prod_r, acc_fin;
  logic [1:0] cnt_r, k_r, sel;
  logic pass_r, div_init_r, neg_r, out_valid_r;
  logic [SQ_W-1:0] rad_r, root_r, bit_r, sq_t;
  logic [4:0] it_r;
  logic [REM_W-1:0] rem_r, den_r;
  logic [QUO_W-1:0] quo_r, q_fin;
  logic signed [VEC_W-1:0] mul_a, mul_b, rot_v, mag_s;
  logic signed [2*VEC_W-1:0] mul_p;
  logic [SQ_W-1:0] rot_mag;
  logic [VEC_W-1:0] div_mag;
  logic signed [QUO_W:0] q_sig;
  logic signed [NRM_W-1:0] q_clamp;
  logic ge, out_free;

  assign sel = (cnt_r == 2'd3) ? 2'd0 : cnt_r;
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop = state_r == S_IDLE && !q_empty;
  assign out_valid = out_valid_r;

  always_comb begin
    if (state_r == S_ROT) begin
      mul_a = VEC_W'($signed(coef[k_r][sel]));
      mul_b = VEC_W'(n_r[sel]);
    end else begin
      mul_a = v_r[sel];
      mul_b = v_r[sel];
    end
    mul_p = mul_a * mul_b;
    acc_fin = acc_r + prod_r;
    rot_mag = acc_fin[SQ_W-1] ? SQ_W'(-acc_fin) : SQ_W'(acc_fin);
    rot_mag = (rot_mag + SQ_W'(2048)) >> 12;
    rot_v = acc_fin[SQ_W-1] ? -$signed(rot_mag[VEC_W-1:0]) : $signed(rot_mag[VEC_W-1:0]);
    sq_t = root_r + bit_r;
    mag_s = v_r[k_r];
    div_mag = mag_s[VEC_W-1] ? VEC_W'(-mag_s) : VEC_W'(mag_s);
    ge = rem_r >= den_r;
    q_fin = {quo_r[QUO_W-2:0], ge};
    q_sig = neg_r ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
    if (q_sig > 18'sd32767) begin
      q_clamp = 16'sh7fff;
    end else if (q_sig < -18'sd32768) begin
      q_clamp = 16'sh8000;
    end else begin
      q_clamp = q_sig[NRM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            pos_r <= q_job.pos;
            for (int k = 0; k < 3; k++) begin
              v_r[k] <= VEC_W'($signed(q_job.nsum[k]));
            end
            pass_r <= 1'b0;
            cnt_r <= 2'd0;
            state_r <= S_SQ;
          end
        end
        S_SQ, S_ROT: begin
          if (cnt_r != 2'd3) begin
            prod_r <= SQ_W'(mul_p);
          end
          acc_r <= (cnt_r == 2'd0) ? '0 : acc_fin;
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3 && state_r == S_SQ) begin
            if ($unsigned(acc_fin) <= SQ_W'(FALLBACK_LIMIT)) begin
              n_r[0] <= '0;
              n_r[1] <= '0;
              n_r[2] <= -16'(UNIT_Q14);
              k_r <= 2'd0;
              state_r <= pass_r ? S_DONE : S_ROT;
            end else begin
              rad_r <= $unsigned(acc_fin);
              root_r <= '0;
              bit_r <= SQ_W'(1) << 42;
              it_r <= 5'd21;
              state_r <= S_SQRT;
            end
          end
          if (cnt_r == 2'd3 && state_r == S_ROT) begin
            v_r[k_r] <= rot_v;
            k_r <= k_r + 2'd1;
            if (k_r == 2'd2) begin
              pass_r <= 1'b1;
              state_r <= S_SQ;
            end
          end
        end
        S_SQRT: begin
          if (rad_r >= sq_t) begin
            rad_r <= rad_r - sq_t;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          it_r <= it_r - 5'd1;
          if (it_r == 5'd0) begin
            k_r <= 2'd0;
            div_init_r <= 1'b1;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_init_r) begin
            rem_r <= REM_W'({div_mag, 14'b0}) + REM_W'(root_r >> 1);
            den_r <= REM_W'(root_r) << 16;
            quo_r <= '0;
            neg_r <= mag_s[VEC_W-1];
            it_r <= 5'd16;
            div_init_r <= 1'b0;
          end else begin
            if (ge) begin
              rem_r <= rem_r - den_r;
            end
            den_r <= den_r >> 1;
            quo_r <= q_fin;
            it_r <= it_r - 5'd1;
            if (it_r == 5'd0) begin
              n_r[k_r] <= q_clamp;
              k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
              div_init_r <= 1'b1;
              if (k_r == 2'd2) begin
                cnt_r <= 2'd0;
                state_r <= pass_r ? S_DONE : S_ROT;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_pos <= pos_r;
            out_face <= {n_r[2], n_r[1], n_r[0]};
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `TFN_ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_valid_r && out_stall, out_valid_r && $stable(out_face))
  `TFN_ASSERT_IMPL(a_pop_idle, clk, rst_n, q_pop, state_r == S_IDLE && !q_empty)
  `TFN_ASSERT_IMPL(a_unit_range, clk, rst_n, out_valid_r, $signed(out_face[0]) <= 16'sd16384 && $signed(out_face[0]) >= -16'sd16384)
endmodule

FILE: design/triangle_face_normal_setup_unit.sv
// Triangle face normal setup unit.
// The input channel (in_valid/in_stall) takes one vertex per transfer: a Q16.16
// position and a Q1.14 normal. Every third vertex closes a triangle; a vertex
// flagged end_of_batch that does not close a triangle drops the partial one.
// The output channel (out_valid/out_stall) carries the three positions and the
// unit face normal after rotation by the three cfg coefficient rows.
// cfg_valid/cfg_ready writes a row; cfg_ready is always high, write while idle.
// A closed triangle enters a two-entry queue; the back end works it through a
// shared multiplier, a one-bit-per-cycle square root and a one-bit-per-cycle
// divider, twice. The back end works one triangle at a time and pops the next
// from the queue only once it is idle again.
// The input stalls only when the queue is full. A stalled result holds in the
// output register while the next triangle is computed behind it.
// Reset clears the vertex count, the normal sum, the queue and the output valid,
// and loads identity coefficient rows.
module triangle_face_normal_setup_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic signed [15:0] in_nrm_x,
  input  logic signed [15:0] in_nrm_y,
  input  logic signed [15:0] in_nrm_z,
  input  logic in_end_of_batch,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] out_a_x,
  output logic signed [31:0] out_a_y,
  output logic signed [31:0] out_a_z,
  output logic signed [31:0] out_b_x,
  output logic signed [31:0] out_b_y,
  output logic signed [31:0] out_b_z,
  output logic signed [31:0] out_c_x,
  output logic signed [31:0] out_c_y,
  output logic signed [31:0] out_c_z,
  output logic signed [15:0] out_face_nx,
  output logic signed [15:0] out_face_ny,
  output logic signed [15:0] out_face_nz,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [47:0] cfg_data
);
  import tfn_pkg::*;

  localparam logic [1:0] REG_X = 2'd0;
  localparam logic [1:0] REG_Y = 2'd1;
  localparam logic [1:0] REG_Z = 2'd2;

  logic [2:0][47:0] coef_r;
  coef_t coef;
  job_t push_job, pop_job;
  logic q_push, q_pop, q_full, q_empty;
  logic [8:0][31:0] out_pos;
  logic [2:0][15:0] out_face;

  assign cfg_ready = 1'b1;
  assign coef = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= 48'd4096;
      coef_r[1] <= 48'd4096 << 16;
      coef_r[2] <= 48'd4096 << 32;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X: coef_r[0] <= cfg_data;
        REG_Y: coef_r[1] <= cfg_data;
        REG_Z: coef_r[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tfn_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_nrm_x(in_nrm_x), .in_nrm_y(in_nrm_y), .in_nrm_z(in_nrm_z),
    .in_end_of_batch(in_end_of_batch), .q_full(q_full), .q_push(q_push),
    .q_job(push_job)
  );

  tfn_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_job(push_job), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_job(pop_job)
  );

  tfn_back u_back (
    .clk(clk), .rst_n(rst_n), .coef(coef), .q_empty(q_empty), .q_job(pop_job),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_pos(out_pos), .out_face(out_face)
  );

  assign out_a_x = out_pos[0];
  assign out_a_y = out_pos[1];
  assign out_a_z = out_pos[2];
  assign out_b_x = out_pos[3];
  assign out_b_y = out_pos[4];
  assign out_b_z = out_pos[5];
  assign out_c_x = out_pos[6];
  assign out_c_y = out_pos[7];
  assign out_c_z = out_pos[8];
  assign out_face_nx = out_face[0];
  assign out_face_ny = out_face[1];
  assign out_face_nz = out_face[2];
endmodule

FILE: test/face_normal_checker.sv
`timescale 1ns / 100ps

module face_normal_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic signed [15:0] in_nrm_x,
  input  logic signed [15:0] in_nrm_y,
  input  logic signed [15:0] in_nrm_z,
  input  logic in_end_of_batch,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [31:0] out_a_x,
  input  logic [31:0] out_a_y,
  input  logic [31:0] out_a_z,
  input  logic [31:0] out_b_x,
  input  logic [31:0] out_b_y,
  input  logic [31:0] out_b_z,
  input  logic [31:0] out_c_x,
  input  logic [31:0] out_c_y,
  input  logic [31:0] out_c_z,
  input  logic [15:0] out_face_nx,
  input  logic [15:0] out_face_ny,
  input  logic [15:0] out_face_nz,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [47:0] cfg_data,
  output int mismatch_count,
  output int triangles_pending,
  output int triangles_checked,
  output int fallback_faces
);

  typedef struct packed {
    logic [8:0][31:0] pos;
    logic [2:0][15:0] nrm;
  } triangle_t;

  logic [2:0][47:0] rows;
  int vertex_count;
  logic [5:0][31:0] first_two;
  int nsum [3];
  triangle_t expected_triangles [$];

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [2:0][15:0] unit_vector(longint vx, longint vy, longint vz);
    longint v [3];
    longint sq;
    longint r;
    longint q;
    logic [2:0][15:0] o;
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    sq = vx * vx + vy * vy + vz * vz;
    if (sq <= 268) begin
      o[0] = 16'sd0;
      o[1] = 16'sd0;
      o[2] = -16'sd16384;
      return o;
    end
    r = floor_sqrt(sq);
    for (int k = 0; k < 3; k++) begin
      q = round_div(v[k] * 16384, r);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      o[k] = q[15:0];
    end
    return o;
  endfunction

  function automatic logic [2:0][15:0] face_normal();
    logic [2:0][15:0] face;
    longint acc [3];
    face = unit_vector(nsum[0], nsum[1], nsum[2]);
    if (nsum[0] * nsum[0] + nsum[1] * nsum[1] + nsum[2] * nsum[2] <= 268) fallback_faces++;
    for (int k = 0; k < 3; k++) begin
      acc[k] = 0;
      for (int j = 0; j < 3; j++) begin
        acc[k] += longint'($signed(rows[k][16*j +: 16])) * longint'($signed(face[j]));
      end
      acc[k] = round_div(acc[k], 4096);
    end
    return unit_vector(acc[0], acc[1], acc[2]);
  endfunction

  task automatic take_vertex();
    logic signed [15:0] n [3];
    triangle_t t;
    n[0] = in_nrm_x;
    n[1] = in_nrm_y;
    n[2] = in_nrm_z;
    for (int k = 0; k < 3; k++) begin
      nsum[k] = (vertex_count == 0) ? int'(n[k]) : nsum[k] + int'(n[k]);
    end
    if (vertex_count < 2) begin
      first_two[vertex_count*3 + 0] = in_pos_x;
      first_two[vertex_count*3 + 1] = in_pos_y;
      first_two[vertex_count*3 + 2] = in_pos_z;
      vertex_count++;
      if (in_end_of_batch) begin
        vertex_count = 0;
        nsum = '{0, 0, 0};
      end
    end else begin
      for (int k = 0; k < 6; k++) t.pos[k] = first_two[k];
      t.pos[6] = in_pos_x;
      t.pos[7] = in_pos_y;
      t.pos[8] = in_pos_z;
      t.nrm = face_normal();
      expected_triangles = {expected_triangles, t};
      vertex_count = 0;
      nsum = '{0, 0, 0};
    end
  endtask

  task automatic compare_triangle();
    triangle_t want;
    triangle_t got;
    string names [12];
    logic [31:0] w;
    logic [31:0] g;
    names = '{"a_x", "a_y", "a_z", "b_x", "b_y", "b_z", "c_x", "c_y", "c_z",
              "face_nx", "face_ny", "face_nz"};
    got.pos = {out_c_z, out_c_y, out_c_x, out_b_z, out_b_y, out_b_x,
               out_a_z, out_a_y, out_a_x};
    got.nrm = {out_face_nz, out_face_ny, out_face_nx};
    if (expected_triangles.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: result transfer with none expected", $time);
      return;
    end
    want = expected_triangles.pop_front();
    triangles_checked++;
    for (int f = 0; f < 12; f++) begin
      w = (f < 9) ? want.pos[f] : {16'd0, want.nrm[f-9]};
      g = (f < 9) ? got.pos[f] : {16'd0, got.nrm[f-9]};
      if (w !== g) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: triangle %0d field %s expected %h actual %h", $time,
                   triangles_checked, names[f], w, g);
        end
      end
    end
  endtask

  initial begin
    mismatch_count = 0;
    triangles_checked = 0;
    fallback_faces = 0;
    triangles_pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rows[0] <= 48'd4096;
      rows[1] <= 48'd4096 << 16;
      rows[2] <= 48'd4096 << 32;
      vertex_count = 0;
      nsum = '{0, 0, 0};
      expected_triangles.delete();
    end else begin
      if (out_valid && !out_stall) compare_triangle();
      if (in_valid && !in_stall) take_vertex();
      if (cfg_valid && cfg_ready && cfg_index < 2'd3) rows[cfg_index] <= cfg_data;
    end
    triangles_pending = expected_triangles.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASE_ITEMS = 240;
  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_Z = 2'd2;
  localparam logic [1:0] ROW_NONE = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [15:0] in_nrm_x, in_nrm_y, in_nrm_z;
  logic in_end_of_batch;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z;
  logic signed [31:0] out_c_x, out_c_y, out_c_z;
  logic signed [15:0] out_face_nx, out_face_ny, out_face_nz;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [47:0] cfg_data;
  int mismatch_count, triangles_pending, triangles_checked, fallback_faces;
  int cycles;
  int vertices_sent;
  bit hold_output;

  triangle_face_normal_setup_unit u_dut (.*);

  face_normal_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int k;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      k = $urandom_range(0, 6);
      if (hold_output) begin
        k = 800;
        hold_output = 0;
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic eob);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_nrm_x <= nx;
    in_nrm_y <= ny;
    in_nrm_z <= nz;
    in_end_of_batch <= eob;
    do @(posedge clk); while (in_stall);
    vertices_sent++;
  endtask

  task automatic random_vertex();
    logic [15:0] n [3];
    int style;
    style = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      case (style)
        0: n[k] = 16'($urandom_range(0, 16)) - 16'd8;
        1: n[k] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        default: n[k] = 16'($urandom);
      endcase
    end
    send_vertex($urandom, $urandom, $urandom, n[0], n[1], n[2],
                $urandom_range(0, 14) == 0);
  endtask

  task automatic write_row(logic [1:0] idx, logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (triangles_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [47:0] row_for(int phase, int r);
    case (phase)
      1: return 48'd0;
      2: return 48'hffff_ffff_ffff;
      3: return 48'h7fff_7fff_7fff;
      4: return 48'h8000_8000_8000;
      5: return 48'd4096 << (16 * ((r + 1) % 3));
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_nrm_x = '0;
    in_nrm_y = '0;
    in_nrm_z = '0;
    in_end_of_batch = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ROW_X;
    cfg_data = '0;
    hold_output = 0;
    vertices_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_vertex(32'h7fffffff, 32'h80000000, 32'h0, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_vertex(32'h80000000, 32'h7fffffff, 32'hffffffff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_vertex(32'h0, 32'h1, 32'hffffffff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_vertex(32'h1, 32'h2, 32'h3, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_vertex(32'h4, 32'h5, 32'h6, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_vertex(32'h7, 32'h8, 32'h9, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_vertex(32'h10000, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 1'b0);
    send_vertex(32'h0, 32'h10000, 32'h0, 16'hc000, 16'h0, 16'h0, 1'b0);
    send_vertex(32'h0, 32'h0, 32'h10000, 16'h0, 16'h0, 16'h0, 1'b0);
    send_vertex(32'h1, 32'h1, 32'h1, 16'h5, 16'h5, 16'h5, 1'b0);
    send_vertex(32'h2, 32'h2, 32'h2, 16'h4, 16'h4, 16'h4, 1'b0);
    send_vertex(32'h3, 32'h3, 32'h3, 16'h0, 16'h0, 16'h0, 1'b0);
    send_vertex(32'hdead, 32'hbeef, 32'h1234, 16'h1000, 16'h2000, 16'h3000, 1'b1);
    send_vertex(32'h5555, 32'haaaa, 32'h1111, 16'h1000, 16'h2000, 16'h3000, 1'b0);
    send_vertex(32'h6666, 32'h7777, 32'h8888, 16'h1000, 16'h2000, 16'h3000, 1'b1);
    send_vertex(32'h9, 32'ha, 32'hb, 16'h0, 16'h4000, 16'h0, 1'b0);
    send_vertex(32'hc, 32'hd, 32'he, 16'h0, 16'h4000, 16'h0, 1'b0);
    send_vertex(32'hf, 32'h10, 32'h11, 16'h0, 16'h4000, 16'h0, 1'b0);
    drain();

    for (int phase = 1; phase <= 8; phase++) begin
      write_row(ROW_X, row_for(phase, 0));
      write_row(ROW_Y, row_for(phase, 1));
      write_row(ROW_Z, row_for(phase, 2));
      write_row(ROW_NONE, {16'($urandom), 32'($urandom)});
      cfg_valid <= 1'b0;
      @(posedge clk);
      if (phase == 3) hold_output = 1;
      for (int i = 0; i < PHASE_ITEMS; i++) random_vertex();
      drain();
    end

    $display("Sent %0d vertices over nine coefficient settings; checked %0d triangles,",
             vertices_sent, triangles_checked);
    $display("%0d of them with a degenerate summed normal.", fallback_faces);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
